/* rtl/gamepad_report_conditioner_top_assert.svh */
// Assertion macros for the checker file of the report conditioner.
`ifndef GAMEPAD_REPORT_CONDITIONER_TOP_ASSERT_SVH
`define GAMEPAD_REPORT_CONDITIONER_TOP_ASSERT_SVH

// Clocked assertion, masked while reset is asserted.
`define GPRC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define GPRC_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/gprc_pkg.sv */
// ----------------------------------------------------------------------------
// gprc_pkg
// Types, constants and helper functions of the gamepad report conditioner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package gprc_pkg;

    localparam int CFG_ADDR_W = 3;

    localparam logic [CFG_ADDR_W-1:0] CFG_WALK_RADIUS  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_JOG_RADIUS   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_RUN_RADIUS   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_FIRST_DELAY  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_REPEAT_PER   = 3'd4;

    localparam logic [7:0]  RST_WALK_RADIUS = 8'd48;
    localparam logic [7:0]  RST_JOG_RADIUS  = 8'd88;
    localparam logic [7:0]  RST_RUN_RADIUS  = 8'd122;
    localparam logic [7:0]  RST_FIRST_DELAY = 8'd32;
    localparam logic [7:0]  RST_REPEAT_PER  = 8'd10;
    localparam logic [15:0] RST_WALK_SQ     = 16'd2304;
    localparam logic [15:0] RST_JOG_SQ      = 16'd7744;
    localparam logic [15:0] RST_RUN_SQ      = 16'd14884;

    localparam logic [15:0] DIR_MASK    = 16'hF000;
    localparam logic [15:0] NONDIR_MASK = 16'h0FFF;
    localparam logic [15:0] DIR_UP      = 16'h1000;
    localparam logic [15:0] DIR_RIGHT   = 16'h2000;
    localparam logic [15:0] DIR_DOWN    = 16'h4000;
    localparam logic [15:0] DIR_LEFT    = 16'h8000;

    localparam logic [1:0] GAIT_IDLE = 2'd0;
    localparam logic [1:0] GAIT_WALK = 2'd1;
    localparam logic [1:0] GAIT_JOG  = 2'd2;
    localparam logic [1:0] GAIT_RUN  = 2'd3;

    localparam logic [7:0] AXIS_CENTER = 8'h80;
    localparam logic [7:0] AXIS_LOW_TH = 8'h10;
    localparam logic [7:0] AXIS_HI_TH  = 8'hE1;
    localparam logic [7:0] QUANT_MASK  = 8'hFC;

    typedef struct packed {
        logic [15:0] walk_sq;
        logic [15:0] jog_sq;
        logic [15:0] run_sq;
    } t_gait_sq;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [1:0] gait;
    } t_stick;

    // Round to a multiple of four, saturating at the top code.
    function automatic logic [7:0] quant(input logic [7:0] v);
        logic [8:0] t;
        t = {1'b0, v} + 9'd2;
        return t[8] ? QUANT_MASK : (t[7:0] & QUANT_MASK);
    endfunction

    function automatic logic [15:0] axis_dir(input logic [7:0] v, input logic is_y);
        logic [15:0] d;
        d = '0;
        if (v < AXIS_LOW_TH) begin
            d = is_y ? DIR_UP : DIR_LEFT;
        end else if (v >= AXIS_HI_TH) begin
            d = is_y ? DIR_DOWN : DIR_RIGHT;
        end
        return d;
    endfunction

    // Up beats down, right beats left.
    function automatic t_stick dir_to_stick(input logic [15:0] b);
        t_stick s;
        s.x    = AXIS_CENTER;
        s.y    = AXIS_CENTER;
        s.gait = GAIT_RUN;
        priority if ((b & DIR_UP) != '0) begin
            if ((b & DIR_RIGHT) != '0) begin
                s.x = 8'hF0;
                s.y = 8'h10;
            end else if ((b & DIR_LEFT) != '0) begin
                s.x = 8'h10;
                s.y = 8'h10;
            end else begin
                s.y = 8'h00;
            end
        end else if ((b & DIR_DOWN) != '0) begin
            if ((b & DIR_RIGHT) != '0) begin
                s.x = 8'hF0;
                s.y = 8'hF0;
            end else if ((b & DIR_LEFT) != '0) begin
                s.x = 8'h10;
                s.y = 8'hF0;
            end else begin
                s.y = 8'hFF;
            end
        end else if ((b & DIR_RIGHT) != '0) begin
            s.x = 8'hFF;
        end else if ((b & DIR_LEFT) != '0) begin
            s.x = 8'h00;
        end else begin
            s.gait = GAIT_IDLE;
        end
        return s;
    endfunction

endpackage

/* rtl/gprc_band.sv */
// ----------------------------------------------------------------------------
// gprc_band
// Classifies the left stick radius into one of four gait bands against
// squared radius thresholds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module gprc_band
    import gprc_pkg::*;
(
    input  logic [7:0] i_x,
    input  logic [7:0] i_y,
    input  t_gait_sq   i_thr,
    output logic [1:0] o_band
);

    logic [7:0]  dx_abs;
    logic [7:0]  dy_abs;
    logic [15:0] dx_sq;
    logic [15:0] dy_sq;
    logic [15:0] r2;

    // Distance from center is at most 128, so it fits eight bits.
    assign dx_abs = i_x[7] ? {1'b0, i_x[6:0]} : (AXIS_CENTER - i_x);
    assign dy_abs = i_y[7] ? {1'b0, i_y[6:0]} : (AXIS_CENTER - i_y);
    assign dx_sq  = 16'(dx_abs) * 16'(dx_abs);
    assign dy_sq  = 16'(dy_abs) * 16'(dy_abs);
    assign r2     = dx_sq + dy_sq;

    always_comb begin
        priority if (r2 <= i_thr.walk_sq) begin
            o_band = GAIT_IDLE;
        end else if (r2 <= i_thr.jog_sq) begin
            o_band = GAIT_WALK;
        end else if (r2 <= i_thr.run_sq) begin
            o_band = GAIT_JOG;
        end else begin
            o_band = GAIT_RUN;
        end
    end

endmodule

/* rtl/gamepad_report_conditioner_top.sv */
// ----------------------------------------------------------------------------
// gamepad_report_conditioner_top
// Conditions raw gamepad reports into held, pressed and auto-repeat masks,
// stick bytes and a gait band.
// ----------------------------------------------------------------------------
// One report is taken per cycle while the input register can take it; a
// stalled output holds the flow. The report lands in an input register,
// then a single pass of logic (band compare, stick mapping, edge and
// repeat update) loads the conditioned state, which is the result register.
// A stalled output holds one more report in the input register before
// ready drops. A report with non-zero status returns accepted low and the
// retained state. Radius thresholds are squared when written, so no
// squaring of thresholds is needed at run time.
`timescale 1ns / 1ps

module gamepad_report_conditioner_top
    import gprc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [7:0]            i_cfg_wdata,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [7:0]            i_status_byte,
    input  logic [7:0]            i_raw_buttons_high,
    input  logic [7:0]            i_raw_buttons_low,
    input  logic [7:0]            i_raw_right_x,
    input  logic [7:0]            i_raw_right_y,
    input  logic [7:0]            i_raw_left_x,
    input  logic [7:0]            i_raw_left_y,
    input  logic                  i_port_number,
    input  logic                  i_analog_mode,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic                  o_accepted,
    output logic [15:0]           o_held_buttons,
    output logic [15:0]           o_new_presses,
    output logic [15:0]           o_repeat_buttons,
    output logic [7:0]            o_left_x,
    output logic [7:0]            o_left_y,
    output logic [7:0]            o_right_x,
    output logic [7:0]            o_right_y,
    output logic [1:0]            o_gait_band
);

    // configuration
    t_gait_sq   r_thr;
    logic [7:0] r_first_delay;
    logic [7:0] r_period;
    logic [15:0] cfg_sq;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_status;
    logic [7:0] r_in_btn_hi;
    logic [7:0] r_in_btn_lo;
    logic [7:0] r_in_rx;
    logic [7:0] r_in_ry;
    logic [7:0] r_in_lx;
    logic [7:0] r_in_ly;
    logic       r_in_port;
    logic       r_in_analog;

    // conditioned state, also the result register
    logic        r_out_valid;
    logic        r_accepted;
    logic [15:0] r_held;
    logic [15:0] r_pressed;
    logic [15:0] r_repeat;
    logic [7:0]  r_countdown;
    logic [7:0]  r_lx;
    logic [7:0]  r_ly;
    logic [7:0]  r_rx;
    logic [7:0]  r_ry;
    logic [1:0]  r_gait;

    logic [15:0] n_held;
    logic [15:0] n_pressed;
    logic [15:0] n_repeat;
    logic [7:0]  n_countdown;
    logic [7:0]  n_lx;
    logic [7:0]  n_ly;
    logic [7:0]  n_rx;
    logic [7:0]  n_ry;
    logic [1:0]  n_gait;

    logic        advance;
    logic        report_ok;
    logic [15:0] held_raw;
    logic [15:0] dir_now;
    logic [15:0] dir_prev;
    logic [7:0]  cnt_dec;
    logic [1:0]  band;
    t_stick      dstk;

    assign cfg_sq = 16'(i_cfg_wdata) * 16'(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr.walk_sq <= RST_WALK_SQ;
            r_thr.jog_sq  <= RST_JOG_SQ;
            r_thr.run_sq  <= RST_RUN_SQ;
            r_first_delay <= RST_FIRST_DELAY;
            r_period      <= RST_REPEAT_PER;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_WALK_RADIUS: r_thr.walk_sq <= cfg_sq;
                CFG_JOG_RADIUS:  r_thr.jog_sq  <= cfg_sq;
                CFG_RUN_RADIUS:  r_thr.run_sq  <= cfg_sq;
                CFG_FIRST_DELAY: r_first_delay <= i_cfg_wdata;
                CFG_REPEAT_PER:  r_period      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Advance when the result slot is empty or being drained.
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_status <= i_status_byte;
            r_in_btn_hi <= i_raw_buttons_high;
            r_in_btn_lo <= i_raw_buttons_low;
            r_in_rx     <= i_raw_right_x;
            r_in_ry     <= i_raw_right_y;
            r_in_lx     <= i_raw_left_x;
            r_in_ly     <= i_raw_left_y;
            r_in_port   <= i_port_number;
            r_in_analog <= i_analog_mode;
        end
    end

    gprc_band u_band (
        .i_x    (r_in_lx),
        .i_y    (r_in_ly),
        .i_thr  (r_thr),
        .o_band (band)
    );

    assign report_ok = (r_in_status == 8'd0);
    assign held_raw  = ~{r_in_btn_hi, r_in_btn_lo};
    assign dstk      = dir_to_stick(held_raw);

    always_comb begin
        n_held = held_raw;
        n_lx   = dstk.x;
        n_ly   = dstk.y;
        n_gait = dstk.gait;
        n_rx   = r_rx;
        n_ry   = r_ry;
        if (r_in_analog) begin
            n_rx = r_in_rx;
            n_ry = r_in_ry;
            if (band == GAIT_IDLE) begin
                // Centered stick on port 0 with a direction held: keep the pad mapping.
                if (r_in_port || ((held_raw & DIR_MASK) == '0)) begin
                    n_lx   = r_in_lx;
                    n_ly   = r_in_ly;
                    n_gait = GAIT_IDLE;
                end
            end else begin
                if (!r_in_port) begin
                    n_held = (held_raw & NONDIR_MASK) | axis_dir(r_in_lx, 1'b0)
                           | axis_dir(r_in_ly, 1'b1);
                end
                n_lx   = quant(r_in_lx);
                n_ly   = quant(r_in_ly);
                n_gait = band;
            end
        end
    end

    assign n_pressed = n_held & ~r_held;
    assign dir_now   = n_held & DIR_MASK;
    assign dir_prev  = r_held & DIR_MASK;
    assign cnt_dec   = r_countdown - 8'd1;

    always_comb begin
        priority if ((dir_now != dir_prev) || (dir_now == '0)) begin
            // restart the delay on any direction change or release
            n_countdown = r_first_delay;
            n_repeat    = n_pressed;
        end else if (cnt_dec == 8'd0) begin
            n_countdown = r_period;
            n_repeat    = dir_now | (n_pressed & NONDIR_MASK);
        end else begin
            n_countdown = cnt_dec;
            n_repeat    = n_pressed & NONDIR_MASK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accepted  <= 1'b0;
            r_held      <= '0;
            r_pressed   <= '0;
            r_repeat    <= '0;
            r_countdown <= '0;
            r_lx        <= '0;
            r_ly        <= '0;
            r_rx        <= '0;
            r_ry        <= '0;
            r_gait      <= GAIT_IDLE;
        end else if (advance) begin
            r_accepted <= report_ok;
            // drop the report but keep the state when status is bad
            if (report_ok) begin
                r_held      <= n_held;
                r_pressed   <= n_pressed;
                r_repeat    <= n_repeat;
                r_countdown <= n_countdown;
                r_lx        <= n_lx;
                r_ly        <= n_ly;
                r_rx        <= n_rx;
                r_ry        <= n_ry;
                r_gait      <= n_gait;
            end
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_accepted       = r_accepted;
    assign o_held_buttons   = r_held;
    assign o_new_presses    = r_pressed;
    assign o_repeat_buttons = r_repeat;
    assign o_left_x         = r_lx;
    assign o_left_y         = r_ly;
    assign o_right_x        = r_rx;
    assign o_right_y        = r_ry;
    assign o_gait_band      = r_gait;

endmodule

/* rtl/gprc_checker.sv */
// ----------------------------------------------------------------------------
// gprc_checker
// Port-level checks of the report conditioner, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "gamepad_report_conditioner_top_assert.svh"

module gprc_checker
    import gprc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic                  o_accepted,
    input logic [15:0]           o_held_buttons,
    input logic [15:0]           o_new_presses,
    input logic [15:0]           o_repeat_buttons
);

    `GPRC_ASSERT_RST(a_no_result_after_reset, i_clk, $past(!i_rst_n) |-> !o_out_valid, "result valid right after reset")

    `GPRC_ASSERT(a_result_holds, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_held_buttons) && $stable(o_repeat_buttons) && $stable(o_accepted)), "stalled result changed")

    `GPRC_ASSERT(a_press_is_held, i_clk, i_rst_n, o_out_valid |-> ((o_new_presses & ~o_held_buttons) == 16'h0000), "press reported for a button not held")

    `GPRC_ASSERT(a_repeat_nondir, i_clk, i_rst_n, o_out_valid |-> ((o_repeat_buttons & NONDIR_MASK) == (o_new_presses & NONDIR_MASK)), "repeat differs from presses outside the direction bits")

endmodule

bind gamepad_report_conditioner_top gprc_checker u_gprc_checker (.*);
